### design/bearing_angle_quantizer_assert.svh
`ifndef BEARING_ANGLE_QUANTIZER_ASSERT_SVH
`define BEARING_ANGLE_QUANTIZER_ASSERT_SVH

// same-cycle implication
`define BAQ_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed");

// next-cycle implication
`define BAQ_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

### design/baq_pkg.sv
package baq_pkg;

  localparam int COORD_BITS = 20;
  localparam int D_BITS     = COORD_BITS + 1;
  localparam int MAG_BITS   = COORD_BITS;
  localparam int NUM_CELLS  = 31;
  localparam int CNT_BITS   = 5;
  localparam int TRIG_BITS  = 62;
  localparam int SPLIT      = 31;
  localparam int TERMS      = 40;

  localparam logic [63:0] PI_Q62  = 64'hC90FDAA22168C234;
  localparam logic [63:0] ONE_Q62 = 64'h4000000000000000;

  localparam logic [7:0] ANG_EAST   = 8'd64;
  localparam logic [7:0] ANG_WEST   = 8'd192;
  localparam logic [7:0] ANG_SOUTH  = 8'd128;
  localparam logic [7:0] ANG_OFFSET = 8'd16;
  localparam logic [6:0] QUAD_STEPS = 7'd64;
  localparam logic [5:0] DIAG_STEPS = 6'd32;

  typedef logic [31:0][63:0]      baq_tab_t;
  typedef logic [TERMS-1:0][63:0] baq_div_t;

  typedef struct packed {
    logic [MAG_BITS-1:0] lo;
    logic [MAG_BITS-1:0] hi;
    logic                le;
    logic                dx_ge0;
    logic                dx_pos;
    logic                dy_pos;
    logic                dy_zero;
    logic                same;
    logic                lo_zero;
    logic                diag;
    logic [CNT_BITS-1:0] cnt;
  } baq_item_t;

  function automatic logic [63:0] baq_mulq(input logic [63:0] a, input logic [63:0] b);
    logic [127:0] p;
    p = {64'd0, a} * {64'd0, b};
    return p[125:62];
  endfunction

  function automatic baq_div_t baq_divs(input logic for_sin);
    baq_div_t d;
    d[0] = 64'd1;
    for (int n = 1; n < TERMS; n++) begin
      d[n] = for_sin ? 64'((2 * n) * (2 * n + 1)) : 64'((2 * n - 1) * (2 * n));
    end
    return d;
  endfunction

  localparam baq_div_t SIN_DIV = baq_divs(1'b1);
  localparam baq_div_t COS_DIV = baq_divs(1'b0);

  function automatic baq_tab_t baq_trig(input logic want_cos);
    baq_tab_t    tab;
    logic [63:0] kk, x, x2, ts, s, tc, c;
    for (int k = 0; k < 32; k++) begin
      kk = 64'(k);
      x  = (PI_Q62 >> 7) * kk + (((PI_Q62 & 64'd127) * kk) >> 7);
      x2 = baq_mulq(x, x);
      ts = x;
      s  = x;
      tc = ONE_Q62;
      c  = ONE_Q62;
      for (int n = 1; n < TERMS; n++) begin
        ts = baq_mulq(ts, x2) / SIN_DIV[n];
        tc = baq_mulq(tc, x2) / COS_DIV[n];
        if (n % 2 == 1) begin
          s = s - ts;
          c = c - tc;
        end else begin
          s = s + ts;
          c = c + tc;
        end
      end
      tab[k] = want_cos ? c : s;
    end
    return tab;
  endfunction

  localparam baq_tab_t SIN_TAB = baq_trig(1'b0);
  localparam baq_tab_t COS_TAB = baq_trig(1'b1);

endpackage

### design/bearing_angle_quantizer.sv
// Bearing quantizer: start and target points in, 256-step bearing and
// eight-way direction out.
// Input channel: in_valid / in_stall with from_x, from_y, to_x, to_y.
// Output channel: out_valid / out_stall with bearing_256, direction_8.
// An item is taken at a clock edge where valid is high and stall is low.
// The front registers the differences and then the sorted magnitudes,
// then 31 boundary cells, each registering the split constant products
// and then the wide compare, pass the item down the chain, and one
// output register closes it. Throughput is one item per cycle while
// out_stall does not hold the chain. When the output holds an item and
// out_stall is high, the whole chain holds and in_stall is raised; the
// held output does not change. Reset (rst, synchronous) empties the
// chain and drops out_valid; the data registers are not reset.
module bearing_angle_quantizer
  import baq_pkg::*;
(
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         in_valid,
  output logic                         in_stall,
  input  logic signed [COORD_BITS-1:0] from_x,
  input  logic signed [COORD_BITS-1:0] from_y,
  input  logic signed [COORD_BITS-1:0] to_x,
  input  logic signed [COORD_BITS-1:0] to_y,
  output logic                         out_valid,
  input  logic                         out_stall,
  output logic [7:0]                   bearing_256,
  output logic [2:0]                   direction_8
);

  logic      en;
  logic      chain_v    [NUM_CELLS+1];
  baq_item_t chain_item [NUM_CELLS+1];

  assign in_stall = out_valid && out_stall;
  assign en       = !in_stall;

  baq_front u_front (
    .clk      (clk),
    .rst      (rst),
    .en       (en),
    .in_v     (in_valid),
    .from_x   (from_x),
    .from_y   (from_y),
    .to_x     (to_x),
    .to_y     (to_y),
    .out_v    (chain_v[0]),
    .out_item (chain_item[0])
  );

  for (genvar k = 1; k <= NUM_CELLS; k++) begin : g_cell
    baq_cell u_cell (
      .clk      (clk),
      .rst      (rst),
      .en       (en),
      .in_v     (chain_v[k-1]),
      .in_item  (chain_item[k-1]),
      .cos_k    (COS_TAB[k][TRIG_BITS-1:0]),
      .sin_k    (SIN_TAB[k][TRIG_BITS-1:0]),
      .out_v    (chain_v[k]),
      .out_item (chain_item[k])
    );
  end

  baq_back u_back (
    .clk         (clk),
    .rst         (rst),
    .en          (en),
    .in_v        (chain_v[NUM_CELLS]),
    .in_item     (chain_item[NUM_CELLS]),
    .out_v       (out_valid),
    .bearing_256 (bearing_256),
    .direction_8 (direction_8)
  );

endmodule

### design/baq_front.sv
module baq_front
  import baq_pkg::*;
(
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         en,
  input  logic                         in_v,
  input  logic signed [COORD_BITS-1:0] from_x,
  input  logic signed [COORD_BITS-1:0] from_y,
  input  logic signed [COORD_BITS-1:0] to_x,
  input  logic signed [COORD_BITS-1:0] to_y,
  output logic                         out_v,
  output baq_item_t                    out_item
);

  logic              v1;
  logic [D_BITS-1:0] dx, dy;
  logic [D_BITS-1:0] nx, ny;
  logic [MAG_BITS-1:0] ax, ay, lo, hi;
  logic              le;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1    <= 1'b0;
      out_v <= 1'b0;
    end else if (en) begin
      v1    <= in_v;
      out_v <= v1;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      dx <= {to_x[COORD_BITS-1], to_x} - {from_x[COORD_BITS-1], from_x};
      dy <= {from_y[COORD_BITS-1], from_y} - {to_y[COORD_BITS-1], to_y};
    end
  end

  always_comb begin
    nx = -dx;
    ny = -dy;
    ax = dx[D_BITS-1] ? nx[MAG_BITS-1:0] : dx[MAG_BITS-1:0];
    ay = dy[D_BITS-1] ? ny[MAG_BITS-1:0] : dy[MAG_BITS-1:0];
    le = (ax <= ay);
    lo = le ? ax : ay;
    hi = le ? ay : ax;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_item.lo      <= lo;
      out_item.hi      <= hi;
      out_item.le      <= le;
      out_item.dx_ge0  <= !dx[D_BITS-1];
      out_item.dx_pos  <= !dx[D_BITS-1] && (dx != '0);
      out_item.dy_pos  <= !dy[D_BITS-1] && (dy != '0);
      out_item.dy_zero <= (dy == '0);
      out_item.same    <= (dx == '0) && (dy == '0);
      out_item.lo_zero <= (lo == '0);
      out_item.diag    <= (lo == hi);
      out_item.cnt     <= '0;
    end
  end

endmodule

### design/baq_cell.sv
module baq_cell
  import baq_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 en,
  input  logic                 in_v,
  input  baq_item_t            in_item,
  input  logic [TRIG_BITS-1:0] cos_k,
  input  logic [TRIG_BITS-1:0] sin_k,
  output logic                 out_v,
  output baq_item_t            out_item
);

  localparam int PROD_BITS = MAG_BITS + SPLIT;
  localparam int WIDE_BITS = MAG_BITS + TRIG_BITS + 1;

  logic                 va;
  baq_item_t            item_a;
  baq_item_t            out_item_next;
  logic [PROD_BITS-1:0] pch, pcl, psh, psl;
  logic [WIDE_BITS-1:0] acc_c, acc_s;
  logic                 pass;

  always_ff @(posedge clk) begin
    if (rst) begin
      va    <= 1'b0;
      out_v <= 1'b0;
    end else if (en) begin
      va    <= in_v;
      out_v <= va;
    end
  end

  // partial products against the split constants
  always_ff @(posedge clk) begin
    if (en) begin
      item_a <= in_item;
      pch <= {{SPLIT{1'b0}}, in_item.lo} * {{MAG_BITS{1'b0}}, cos_k[TRIG_BITS-1:SPLIT]};
      pcl <= {{SPLIT{1'b0}}, in_item.lo} * {{MAG_BITS{1'b0}}, cos_k[SPLIT-1:0]};
      psh <= {{SPLIT{1'b0}}, in_item.hi} * {{MAG_BITS{1'b0}}, sin_k[TRIG_BITS-1:SPLIT]};
      psl <= {{SPLIT{1'b0}}, in_item.hi} * {{MAG_BITS{1'b0}}, sin_k[SPLIT-1:0]};
    end
  end

  always_comb begin
    acc_c = (WIDE_BITS'(pch) << SPLIT) + WIDE_BITS'(pcl);
    acc_s = (WIDE_BITS'(psh) << SPLIT) + WIDE_BITS'(psl);
    pass  = (acc_c > acc_s);
    out_item_next     = item_a;
    out_item_next.cnt = item_a.cnt + CNT_BITS'(pass);
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_item <= out_item_next;
    end
  end

endmodule

### design/baq_back.sv
module baq_back
  import baq_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       en,
  input  logic       in_v,
  input  baq_item_t  in_item,
  output logic       out_v,
  output logic [7:0] bearing_256,
  output logic [2:0] direction_8
);

  logic       exact;
  logic [5:0] f, f1;
  logic [6:0] fl, ce;
  logic [7:0] t, bearing;

  always_comb begin
    if (in_item.lo_zero) begin
      f     = '0;
      exact = 1'b1;
    end else if (in_item.diag) begin
      f     = DIAG_STEPS;
      exact = 1'b1;
    end else begin
      f     = {1'b0, in_item.cnt};
      exact = 1'b0;
    end
    f1 = exact ? f : f + 6'd1;
    fl = in_item.le ? {1'b0, f} : QUAD_STEPS - {1'b0, f1};
    ce = in_item.le ? {1'b0, f1} : QUAD_STEPS - {1'b0, f};
    if (in_item.dy_zero) begin
      t = in_item.dx_pos ? ANG_EAST : ANG_WEST;
    end else if (in_item.dy_pos) begin
      t = in_item.dx_ge0 ? {1'b0, fl} : 8'd0 - {1'b0, fl};
    end else begin
      t = in_item.dx_ge0 ? ANG_SOUTH - {1'b0, ce} : ANG_SOUTH + {1'b0, ce};
    end
    bearing = in_item.same ? 8'd0 : t + ANG_OFFSET;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_v <= 1'b0;
    end else if (en) begin
      out_v <= in_v;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      bearing_256 <= bearing;
      direction_8 <= bearing[7:5];
    end
  end

endmodule

### design/baq_checker.sv
`include "bearing_angle_quantizer_assert.svh"

module baq_checker (
  input logic       clk,
  input logic       rst,
  input logic       in_valid,
  input logic       in_stall,
  input logic       out_valid,
  input logic       out_stall,
  input logic [7:0] bearing_256,
  input logic [2:0] direction_8
);

  `BAQ_ASSERT_NOW(a_dir_matches, out_valid, direction_8 == bearing_256[7:5])
  `BAQ_ASSERT_NOW(a_stall_follows, out_valid && out_stall, in_stall)
  `BAQ_ASSERT_NOW(a_no_idle_stall, !out_valid || !out_stall, !in_stall)
  `BAQ_ASSERT_NEXT(a_out_hold, out_valid && out_stall, out_valid && $stable(bearing_256))

endmodule

bind bearing_angle_quantizer baq_checker u_baq_checker (.*);

### bench/tb.sv
module tb;
  import baq_pkg::*;

  typedef logic signed [COORD_BITS-1:0] coord_t;
  typedef struct packed {
    logic [7:0] bearing;
    logic [2:0] facing;
  } heading_t;

  localparam int RANDOM_ITEMS = 1900;
  localparam int HOLD_CYCLES  = 400;

  localparam int DIRECTED [22][4] = '{
    '{0, 0, 0, 0},
    '{-524288, 524287, -524288, 524287},
    '{0, 0, 5, 0},
    '{0, 0, -5, 0},
    '{0, 0, 0, -7},
    '{0, 0, 0, 7},
    '{0, 0, 3, -3},
    '{0, 0, -3, -3},
    '{0, 0, 3, 3},
    '{0, 0, -3, 3},
    '{-524288, -524288, 524287, 524287},
    '{524287, 524287, -524288, -524288},
    '{-524288, 524287, 524287, -524288},
    '{524287, -524288, -524288, 524287},
    '{-524288, 524287, 524287, 524286},
    '{0, 524287, 1, -524288},
    '{-1, -1, -1, -1},
    '{0, 0, 1, -2},
    '{0, 0, 2, -1},
    '{0, 0, -2, 1},
    '{-524288, 0, 524287, 0},
    '{0, -524288, 0, 524287}
  };

  class heading_board;
    logic [63:0] sin_q62 [65];
    heading_t    due_q [$];
    int          errors;

    // sin(k*pi/128) for k = 0..64 in Q2.62; cos(k*pi/128) is sin_q62[64-k]
    function new();
      logic [63:0] x, x2, term, s;
      for (int k = 0; k <= 64; k++) begin
        x    = 64'((128'(PI_Q62) * 128'(k)) >> 7);
        x2   = q62_mul(x, x);
        term = x;
        s    = x;
        for (int n = 1; n < 30; n++) begin
          term = q62_mul(term, x2) / 64'((2 * n) * (2 * n + 1));
          if (n % 2 == 1) s = s - term;
          else s = s + term;
        end
        sin_q62[k] = s;
      end
      errors = 0;
    endfunction

    function logic [63:0] q62_mul(logic [63:0] a, logic [63:0] b);
      logic [127:0] p;
      p = 128'(a) * 128'(b);
      return p[125:62];
    endfunction

    // number of pi/128 steps below atan(lo/hi), for 0 < lo < hi
    function int boundaries_passed(logic [63:0] lo, logic [63:0] hi);
      int cnt;
      cnt = 0;
      for (int k = 1; k < 32; k++) begin
        if (128'(lo) * 128'(sin_q62[64 - k]) > 128'(hi) * 128'(sin_q62[k])) cnt++;
      end
      return cnt;
    endfunction

    function heading_t predict(coord_t fx, coord_t fy, coord_t tx, coord_t ty);
      longint   dx, dy, ax, ay, lo, hi;
      int       f, fl, ce, ang;
      bit       exact;
      heading_t h;
      dx = longint'(tx) - longint'(fx);
      dy = longint'(fy) - longint'(ty);
      h  = '0;
      if (dx == 0 && dy == 0) return h;
      if (dy == 0) begin
        ang = (dx > 0) ? int'(ANG_EAST) : int'(ANG_WEST);
      end else begin
        ax = (dx < 0) ? -dx : dx;
        ay = (dy < 0) ? -dy : dy;
        lo = (ax < ay) ? ax : ay;
        hi = (ax < ay) ? ay : ax;
        if (lo == 0) begin
          f     = 0;
          exact = 1'b1;
        end else if (lo == hi) begin
          f     = int'(DIAG_STEPS);
          exact = 1'b1;
        end else begin
          f     = boundaries_passed(64'(lo), 64'(hi));
          exact = 1'b0;
        end
        if (ax <= ay) begin
          fl = f;
          ce = exact ? f : f + 1;
        end else begin
          fl = int'(QUAD_STEPS) - (exact ? f : f + 1);
          ce = int'(QUAD_STEPS) - f;
        end
        if (dy > 0) ang = (dx >= 0) ? fl : 256 - fl;
        else ang = (dx >= 0) ? int'(ANG_SOUTH) - ce : int'(ANG_SOUTH) + ce;
      end
      h.bearing = 8'(ang + int'(ANG_OFFSET));
      h.facing  = h.bearing[7:5];
      return h;
    endfunction

    function void note_points(coord_t fx, coord_t fy, coord_t tx, coord_t ty);
      due_q.push_back(predict(fx, fy, tx, ty));
    endfunction

    task report(string what);
      errors++;
      if (errors <= 40) $display("mismatch: %s", what);
    endtask

    task check_heading(logic [7:0] b, logic [2:0] d);
      heading_t e;
      if (due_q.size() == 0) begin
        report($sformatf("unexpected item, bearing %0d direction %0d", b, d));
        return;
      end
      e = due_q.pop_front();
      if (b !== e.bearing) report($sformatf("bearing_256 got %0d want %0d", b, e.bearing));
      if (d !== e.facing) report($sformatf("direction_8 got %0d want %0d", d, e.facing));
    endtask

    function int outstanding();
      return due_q.size();
    endfunction
  endclass

  logic       clk       = 1'b0;
  logic       rst       = 1'b1;
  logic       in_valid  = 1'b0;
  logic       in_stall;
  coord_t     from_x    = '0;
  coord_t     from_y    = '0;
  coord_t     to_x      = '0;
  coord_t     to_y      = '0;
  logic       out_valid;
  logic       out_stall = 1'b0;
  logic [7:0] bearing_256;
  logic [2:0] direction_8;

  heading_board board = new();
  int burst_left = 0;
  int hold_ask   = 0;
  int hold_done  = 0;

  bearing_angle_quantizer i_dut (
    .clk,
    .rst,
    .in_valid,
    .in_stall,
    .from_x,
    .from_y,
    .to_x,
    .to_y,
    .out_valid,
    .out_stall,
    .bearing_256,
    .direction_8
  );

  always #1 clk = ~clk;

  // outputs are stable between edges; sample them at the falling edge before the taking edge
  always @(negedge clk) begin
    if (!rst && out_valid && !out_stall) board.check_heading(bearing_256, direction_8);
  end

  initial begin
    int mode, left, phase;
    mode  = 0;
    left  = 0;
    phase = 0;
    forever begin
      @(posedge clk);
      if (hold_ask != hold_done) begin
        hold_done = hold_ask;
        out_stall <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
      end else begin
        if (left == 0) begin
          mode = $urandom_range(0, 3);
          left = $urandom_range(64, 256);
        end
        left--;
        phase++;
        case (mode)
          0: out_stall <= 1'b0;
          1: out_stall <= ($urandom_range(0, 3) == 0);
          2: out_stall <= ($urandom_range(0, 3) != 0);
          default: out_stall <= (phase % 7 < 3);
        endcase
      end
    end
  end

  task automatic offer(coord_t fx, coord_t fy, coord_t tx, coord_t ty);
    bit took;
    in_valid <= 1'b1;
    from_x   <= fx;
    from_y   <= fy;
    to_x     <= tx;
    to_y     <= ty;
    do begin
      @(negedge clk);
      took = !in_stall;
      @(posedge clk);
    end while (!took);
    board.note_points(fx, fy, tx, ty);
  endtask

  task automatic rest(int n);
    in_valid <= 1'b0;
    repeat (n) @(posedge clk);
  endtask

  task automatic pace();
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      burst_left = $urandom_range(0, 40);
      rest($urandom_range(1, ($urandom_range(0, 7) == 0) ? 80 : 8));
    end
  endtask

  task automatic drain();
    rest(1);
    while (board.outstanding() != 0) @(posedge clk);
  endtask

  function automatic int rim_coord();
    case ($urandom_range(0, 4))
      0: return -524288;
      1: return 524287;
      2: return 0;
      3: return -1;
      default: return int'(coord_t'($urandom));
    endcase
  endfunction

  initial begin
    coord_t fx, fy, tx, ty;
    int     sel, dx, dy, mag, lo, kk;
    bit     by_delta;
    repeat (5) @(posedge clk);
    rst <= 1'b0;

    foreach (DIRECTED[i]) begin
      offer(coord_t'(DIRECTED[i][0]), coord_t'(DIRECTED[i][1]),
            coord_t'(DIRECTED[i][2]), coord_t'(DIRECTED[i][3]));
      pace();
    end

    for (int i = 0; i < RANDOM_ITEMS; i++) begin
      if (i == 600 || i == 1500) hold_ask++;
      if (i == 1200 || $urandom_range(0, 299) == 0) drain();
      sel      = $urandom_range(0, 9);
      by_delta = 1'b1;
      dx       = 0;
      dy       = 0;
      case (sel)
        0, 1, 2, 3: begin
          by_delta = 1'b0;
          fx = coord_t'($urandom);
          fy = coord_t'($urandom);
          tx = coord_t'($urandom);
          ty = coord_t'($urandom);
        end
        4: begin
          dx = $urandom_range(0, 80) - 40;
          dy = $urandom_range(0, 80) - 40;
        end
        5: begin
          mag = $urandom_range(1, 520000);
          if ($urandom_range(0, 1)) dx = $urandom_range(0, 1) ? -mag : mag;
          else dy = $urandom_range(0, 1) ? -mag : mag;
        end
        6: begin
          mag = $urandom_range(0, 1) ? $urandom_range(1, 50) : $urandom_range(1, 520000);
          dx  = $urandom_range(0, 1) ? -mag : mag;
          dy  = $urandom_range(0, 1) ? -mag : mag;
        end
        7: begin
          // land next to a step boundary
          kk  = $urandom_range(1, 31);
          mag = $urandom_range(2, 520000);
          lo  = int'(mag * $tan(kk * 3.141592653589793 / 128.0)) + $urandom_range(0, 2) - 1;
          if (lo < 0) lo = 0;
          if (lo > mag) lo = mag;
          if ($urandom_range(0, 1)) begin
            dx = lo;
            dy = mag;
          end else begin
            dx = mag;
            dy = lo;
          end
          if ($urandom_range(0, 1)) dx = -dx;
          if ($urandom_range(0, 1)) dy = -dy;
        end
        8: begin
          by_delta = 1'b0;
          fx = coord_t'(rim_coord());
          fy = coord_t'(rim_coord());
          tx = coord_t'(rim_coord());
          ty = coord_t'(rim_coord());
        end
        default: begin
          dx = $urandom_range(0, 6) - 3;
          dy = $urandom_range(0, 6) - 3;
        end
      endcase
      if (by_delta) begin
        fx = coord_t'(int'($urandom_range(0, 1000)) - 500 - dx / 2);
        fy = coord_t'(int'($urandom_range(0, 1000)) - 500 + dy / 2);
        tx = coord_t'(int'(fx) + dx);
        ty = coord_t'(int'(fy) - dy);
      end
      offer(fx, fy, tx, ty);
      pace();
    end

    drain();
    repeat (150) @(posedge clk);
    if (board.errors == 0 && board.outstanding() == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

  initial begin
    #400000;
    $display("tb: failure");
    $finish;
  end

endmodule

### sim.f
+incdir+design
design/baq_pkg.sv
design/baq_front.sv
design/baq_cell.sv
design/baq_back.sv
design/bearing_angle_quantizer.sv
design/baq_checker.sv
bench/tb.sv
